/* src/wsd_pkg.sv */
// Shared types and constants for the WebSocket frame deframer.
package wsd_pkg;

  // Parser phase within a frame header or payload
  typedef enum logic [2:0] {
    PH_FIRST,
    PH_SECOND,
    PH_EXT16,
    PH_EXT64,
    PH_MASK,
    PH_DATA
  } phase_e;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_DATA   = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_RSV       = 3'd1,
    ERR_OPCODE    = 3'd2,
    ERR_UNMASKED  = 3'd3,
    ERR_NONMIN    = 3'd4,
    ERR_TOO_LARGE = 3'd5,
    ERR_CTRL_FRAG = 3'd6,
    ERR_CTRL_SIZE = 3'd7
  } err_e;

  // Configuration register indexes
  localparam logic CFG_MAX_PAYLOAD = 1'b0;
  localparam logic CFG_MAX_CTRL    = 1'b1;

  localparam logic [31:0] MAX_PAYLOAD_RST = 32'd1048576;
  localparam logic [6:0]  MAX_CTRL_RST    = 7'd125;

  // Known opcodes
  localparam logic [3:0] OP_CONT  = 4'h0;
  localparam logic [3:0] OP_TEXT  = 4'h1;
  localparam logic [3:0] OP_BIN   = 4'h2;
  localparam logic [3:0] OP_CLOSE = 4'h8;
  localparam logic [3:0] OP_PING  = 4'h9;
  localparam logic [3:0] OP_PONG  = 4'hA;

  // Length escape codes in the second header byte
  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  // Smallest lengths that need each extended form
  localparam logic [63:0] MIN_EXT16 = 64'd126;
  localparam logic [63:0] MIN_EXT64 = 64'd65536;

  localparam logic [3:0] HDR_CNT_EXT16 = 4'd2;
  localparam logic [3:0] HDR_CNT_EXT64 = 4'd8;
  localparam logic [3:0] HDR_CNT_MASK  = 4'd4;

  typedef struct packed {
    logic [31:0] max_payload;
    logic [6:0]  max_ctrl;
  } cfg_t;

  typedef struct packed {
    kind_e       kind;
    logic        fin;
    logic [3:0]  opcode;
    logic [31:0] payload_length;
    logic [7:0]  data_out;
    logic        last;
    err_e        err_code;
  } res_t;

endpackage

/* src/wsd_parser.sv */
// Frame header parser, length checks and payload unmasking for one byte per cycle while adv_i is high.
module wsd_parser (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            adv_i,
  input  logic [7:0]      in_data_i,
  input  logic            in_restart_i,
  input  wsd_pkg::cfg_t   cfg_i,
  output logic            res_valid_o,
  output wsd_pkg::res_t   res_o
);

  wsd_pkg::phase_e phase_q, phase_d;
  logic        fin_q, fin_d;
  logic [3:0]  op_q, op_d;
  logic [63:0] acc_q, acc_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [31:0] mask_q, mask_d;
  logic [31:0] rem_q, rem_d;
  logic [1:0]  pos_q, pos_d;
  logic        halted_q, halted_d;

  logic [63:0]   len_val;
  wsd_pkg::err_e len_err;
  logic          nonmin;
  logic          known_op;
  logic          cnt_last;
  logic [7:0]    key_byte;
  wsd_pkg::err_e err_w;
  logic          hdr_w;
  logic          dat_w;

  function automatic wsd_pkg::err_e length_check(input logic [63:0] len,
                                                 input logic fin,
                                                 input logic ctl,
                                                 input wsd_pkg::cfg_t cfg);
    wsd_pkg::err_e e;
    e = wsd_pkg::ERR_NONE;
    if (len > {32'b0, cfg.max_payload}) begin
      e = wsd_pkg::ERR_TOO_LARGE;
    end else if (ctl) begin
      if (!fin) begin
        e = wsd_pkg::ERR_CTRL_FRAG;
      end else if (len > {57'b0, cfg.max_ctrl}) begin
        e = wsd_pkg::ERR_CTRL_SIZE;
      end
    end
    return e;
  endfunction

  assign len_val  = (phase_q == wsd_pkg::PH_SECOND) ? {57'b0, in_data_i[6:0]}
                                                     : {acc_q[55:0], in_data_i};
  assign len_err  = length_check(len_val, fin_q, op_q[3], cfg_i);
  assign nonmin   = (phase_q == wsd_pkg::PH_EXT16) ? (len_val < wsd_pkg::MIN_EXT16)
                                                    : (len_val < wsd_pkg::MIN_EXT64);
  assign known_op = (in_data_i[3:0] == wsd_pkg::OP_CONT)  ||
                    (in_data_i[3:0] == wsd_pkg::OP_TEXT)  ||
                    (in_data_i[3:0] == wsd_pkg::OP_BIN)   ||
                    (in_data_i[3:0] == wsd_pkg::OP_CLOSE) ||
                    (in_data_i[3:0] == wsd_pkg::OP_PING)  ||
                    (in_data_i[3:0] == wsd_pkg::OP_PONG);
  assign cnt_last = (cnt_q == 4'd1);

  // Key bytes are used from the most significant one down
  always_comb begin
    unique case (pos_q)
      2'd0:    key_byte = mask_q[31:24];
      2'd1:    key_byte = mask_q[23:16];
      2'd2:    key_byte = mask_q[15:8];
      default: key_byte = mask_q[7:0];
    endcase
  end

  // Result selection
  always_comb begin
    err_w = wsd_pkg::ERR_NONE;
    hdr_w = 1'b0;
    dat_w = 1'b0;
    if (!in_restart_i && !halted_q) begin
      unique case (phase_q)
        wsd_pkg::PH_FIRST: begin
          if (in_data_i[6:4] != 3'b0) begin
            err_w = wsd_pkg::ERR_RSV;
          end else if (!known_op) begin
            err_w = wsd_pkg::ERR_OPCODE;
          end
        end
        wsd_pkg::PH_SECOND: begin
          if (!in_data_i[7]) begin
            err_w = wsd_pkg::ERR_UNMASKED;
          end else if (in_data_i[6:0] != wsd_pkg::LEN_EXT16 &&
                       in_data_i[6:0] != wsd_pkg::LEN_EXT64) begin
            err_w = len_err;
          end
        end
        wsd_pkg::PH_EXT16, wsd_pkg::PH_EXT64: begin
          if (cnt_last) begin
            err_w = nonmin ? wsd_pkg::ERR_NONMIN : len_err;
          end
        end
        wsd_pkg::PH_MASK: hdr_w = cnt_last;
        wsd_pkg::PH_DATA: dat_w = 1'b1;
        default: ;
      endcase
    end
  end

  always_comb begin
    res_valid_o          = (err_w != wsd_pkg::ERR_NONE) || hdr_w || dat_w;
    res_o.err_code       = err_w;
    res_o.fin            = (phase_q == wsd_pkg::PH_FIRST) ? in_data_i[7] : fin_q;
    res_o.opcode         = (phase_q == wsd_pkg::PH_FIRST) ? in_data_i[3:0] : op_q;
    res_o.data_out       = dat_w ? (in_data_i ^ key_byte) : 8'd0;
    if (err_w != wsd_pkg::ERR_NONE) begin
      res_o.kind           = wsd_pkg::KIND_ERROR;
      res_o.payload_length = 32'd0;
      res_o.last           = 1'b1;
    end else if (hdr_w) begin
      res_o.kind           = wsd_pkg::KIND_HEADER;
      res_o.payload_length = acc_q[31:0];
      res_o.last           = (acc_q[31:0] == 32'd0);
    end else begin
      res_o.kind           = wsd_pkg::KIND_DATA;
      res_o.payload_length = acc_q[31:0];
      res_o.last           = (rem_q == 32'd1);
    end
  end

  // Next state
  always_comb begin
    phase_d  = phase_q;
    fin_d    = fin_q;
    op_d     = op_q;
    acc_d    = acc_q;
    cnt_d    = cnt_q;
    mask_d   = mask_q;
    rem_d    = rem_q;
    pos_d    = pos_q;
    halted_d = halted_q;
    if (in_restart_i) begin
      phase_d  = wsd_pkg::PH_FIRST;
      fin_d    = 1'b0;
      op_d     = 4'd0;
      acc_d    = 64'd0;
      cnt_d    = 4'd0;
      mask_d   = 32'd0;
      rem_d    = 32'd0;
      pos_d    = 2'd0;
      halted_d = 1'b0;
    end else if (!halted_q) begin
      if (err_w != wsd_pkg::ERR_NONE) begin
        halted_d = 1'b1;
      end
      unique case (phase_q)
        wsd_pkg::PH_FIRST: begin
          fin_d  = in_data_i[7];
          op_d   = in_data_i[3:0];
          acc_d  = 64'd0;
          mask_d = 32'd0;
          pos_d  = 2'd0;
          rem_d  = 32'd0;
          if (err_w == wsd_pkg::ERR_NONE) begin
            phase_d = wsd_pkg::PH_SECOND;
          end
        end
        wsd_pkg::PH_SECOND: begin
          if (in_data_i[7]) begin
            if (in_data_i[6:0] == wsd_pkg::LEN_EXT16) begin
              acc_d   = 64'd0;
              phase_d = wsd_pkg::PH_EXT16;
              cnt_d   = wsd_pkg::HDR_CNT_EXT16;
            end else if (in_data_i[6:0] == wsd_pkg::LEN_EXT64) begin
              acc_d   = 64'd0;
              phase_d = wsd_pkg::PH_EXT64;
              cnt_d   = wsd_pkg::HDR_CNT_EXT64;
            end else begin
              acc_d = len_val;
              if (err_w == wsd_pkg::ERR_NONE) begin
                phase_d = wsd_pkg::PH_MASK;
                cnt_d   = wsd_pkg::HDR_CNT_MASK;
              end
            end
          end
        end
        wsd_pkg::PH_EXT16, wsd_pkg::PH_EXT64: begin
          acc_d = len_val;
          cnt_d = cnt_q - 4'd1;
          if (cnt_last && err_w == wsd_pkg::ERR_NONE) begin
            phase_d = wsd_pkg::PH_MASK;
            cnt_d   = wsd_pkg::HDR_CNT_MASK;
          end
        end
        wsd_pkg::PH_MASK: begin
          mask_d = {mask_q[23:0], in_data_i};
          cnt_d  = cnt_q - 4'd1;
          if (cnt_last) begin
            rem_d   = acc_q[31:0];
            pos_d   = 2'd0;
            phase_d = (acc_q[31:0] == 32'd0) ? wsd_pkg::PH_FIRST : wsd_pkg::PH_DATA;
          end
        end
        wsd_pkg::PH_DATA: begin
          rem_d = rem_q - 32'd1;
          pos_d = pos_q + 2'd1;
          if (rem_q == 32'd1) begin
            phase_d = wsd_pkg::PH_FIRST;
          end
        end
        default: phase_d = wsd_pkg::PH_FIRST;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= wsd_pkg::PH_FIRST;
      fin_q    <= 1'b0;
      op_q     <= 4'd0;
      acc_q    <= 64'd0;
      cnt_q    <= 4'd0;
      mask_q   <= 32'd0;
      rem_q    <= 32'd0;
      pos_q    <= 2'd0;
      halted_q <= 1'b0;
    end else if (adv_i) begin
      phase_q  <= phase_d;
      fin_q    <= fin_d;
      op_q     <= op_d;
      acc_q    <= acc_d;
      cnt_q    <= cnt_d;
      mask_q   <= mask_d;
      rem_q    <= rem_d;
      pos_q    <= pos_d;
      halted_q <= halted_d;
    end
  end

  a_err_halts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && res_valid_o && res_o.kind == wsd_pkg::KIND_ERROR |=> halted_q)
    else $error("error result did not halt the parser");

  a_halted_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q && !in_restart_i |-> !res_valid_o)
    else $error("result produced while halted");

  a_rem_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && phase_q == wsd_pkg::PH_DATA && !halted_q && !in_restart_i
    |=> rem_q == $past(rem_q) - 32'd1)
    else $error("payload byte count did not step down");

  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.kind == wsd_pkg::KIND_ERROR |-> res_o.last)
    else $error("error result without last");

endmodule

/* src/wsd_out_reg.sv */
// Result register between the parser and the output stream.
module wsd_out_reg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  wsd_pkg::res_t in_res_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  output wsd_pkg::res_t out_res_o,
  input  logic          out_ready_i
);

  logic          valid_q;
  wsd_pkg::res_t res_q;

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_res_o   = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      res_q <= in_res_i;
    end
  end

endmodule

/* src/websocket_frame_deframer.sv */
// Top level of the WebSocket client-to-server frame deframer.
// Takes one frame byte per transaction and sustains one byte per clock while the output
// accepts results; each byte passes an input register, one pass through the parser's
// next-state logic, and a result register. A byte with tuser set restarts
// the parser and clears a halt after a protocol error. The header result (kind 0) comes with
// the last masking key byte, then one kind 1 result per payload byte, unmasked; kind 2 reports
// the first violation and all bytes are dropped until restart. There is no clearing pass after
// reset. Write configuration only while no transaction is in flight.
module websocket_frame_deframer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_in
  input  logic        s_axis_tuser,   // [0] restart
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] fin, [4:1] opcode, [36:5] payload_length, [44:37] data_out, [47:45] err_code
  output logic [47:0] m_axis_tdata,
  output logic [1:0]  m_axis_tuser,   // [1:0] kind
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  wsd_pkg::cfg_t cfg_q;
  logic          in_valid_q;
  logic [7:0]    in_data_q;
  logic          in_restart_q;
  logic          adv;
  logic          out_in_ready;
  logic          res_valid;
  wsd_pkg::res_t res;
  wsd_pkg::res_t out_res;

  assign cfg_ready_o   = 1'b1;
  assign adv           = in_valid_q && out_in_ready;
  assign s_axis_tready = !in_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_payload <= wsd_pkg::MAX_PAYLOAD_RST;
      cfg_q.max_ctrl    <= wsd_pkg::MAX_CTRL_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        wsd_pkg::CFG_MAX_PAYLOAD: cfg_q.max_payload <= cfg_data_i;
        wsd_pkg::CFG_MAX_CTRL:    cfg_q.max_ctrl    <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_data_q    <= s_axis_tdata;
      in_restart_q <= s_axis_tuser;
    end
  end

  wsd_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .adv_i        (adv),
    .in_data_i    (in_data_q),
    .in_restart_i (in_restart_q),
    .cfg_i        (cfg_q),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  wsd_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (adv && res_valid),
    .in_res_i    (res),
    .in_ready_o  (out_in_ready),
    .out_valid_o (m_axis_tvalid),
    .out_res_o   (out_res),
    .out_ready_i (m_axis_tready)
  );

  assign m_axis_tdata = {out_res.err_code, out_res.data_out, out_res.payload_length,
                         out_res.opcode, out_res.fin};
  assign m_axis_tuser = out_res.kind;
  assign m_axis_tlast = out_res.last;

endmodule
